// File: rtl/fpsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// Shared widths, types and constants of the fixed-point square root block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsqrt_pkg;

    // Input item width and fixed-point format limits.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_W     = 5;
    localparam int FRAC_MAX   = 30;
    localparam int FRAC_RESET = 16;

    // Result and search widths.
    localparam int ROOT_W   = DATA_WIDTH - 1;    // candidate roots and result
    localparam int BOUND_W  = DATA_WIDTH;        // lower and upper search bounds
    localparam int SQ_W     = 2 * ROOT_W;        // square of a candidate
    localparam int SCALED_W = SQ_W + 1;          // input scaled by the fraction bits
    localparam int TDATA_IN_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((ROOT_W + 7) / 8) * 8;

    typedef logic [FRAC_W-1:0]   t_frac;
    typedef logic [ROOT_W-1:0]   t_root;
    typedef logic [BOUND_W-1:0]  t_bound;
    typedef logic [SQ_W-1:0]     t_square;
    typedef logic [SCALED_W-1:0] t_scaled;

endpackage : fpsqrt_pkg

`default_nettype wire

// File: rtl/fpsqrt_sqr.sv
// ----------------------------------------------------------------------------
// fpsqrt_sqr
// Registered squarer shared by every step of the root search.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_sqr (
    input  wire                      i_clk,
    input  wire fpsqrt_pkg::t_root   i_cand,
    output fpsqrt_pkg::t_square      o_square
);
    import fpsqrt_pkg::*;

    t_square r_square;

    // One full-width product per cycle, registered before the compare.
    always_ff @(posedge i_clk) begin
        r_square <= SQ_W'(i_cand) * SQ_W'(i_cand);
    end

    assign o_square = r_square;

endmodule : fpsqrt_sqr

`default_nettype wire

// File: rtl/fixed_point_sqrt_bsearch_top.sv
// ----------------------------------------------------------------------------
// fixed_point_sqrt_bsearch_top
// Fixed-point square root found by binary search over candidate roots.
// ----------------------------------------------------------------------------
// Usage:
//   An item on the s_axis channel is one signed fixed-point value; the
//   m_axis channel returns one item per input, the root in the same format.
//   The number of fraction bits is written through i_cfg_we / i_cfg_wdata;
//   the user must write it only while the block is idle, as the block does
//   not enforce this. Values above thirty act as thirty. Each search step
//   passes through the registered squarer (ST_SQ), then compares the square
//   against the scaled input and moves a bound (ST_CMP). The search over
//   [0, max(x, 1.0)] needs at most 32 steps; a zero or negative input skips
//   the search. The squarer loop sets the rate: one item at a time.
//   s_axis_tready is high only while no search runs. A finished result sits
//   in an output register, so the next item is taken while it waits; if the
//   receiver still stalls when the next search ends, that search holds its
//   result until the register frees up.
//   Reset empties the output register, returns to idle and sets the fraction
//   bits to sixteen.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_sqrt_bsearch_top (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // Configuration write: fraction bits.
    input  wire                                     i_cfg_we,
    input  wire  fpsqrt_pkg::t_frac                 i_cfg_wdata,
    // Input items.
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire  [fpsqrt_pkg::TDATA_IN_W-1:0]       s_axis_tdata,  // [31:0] value
    // Result items.
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    output logic [fpsqrt_pkg::TDATA_OUT_W-1:0]      m_axis_tdata   // [30:0] root, [31] zero
);
    import fpsqrt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_frac      r_frac;
    t_bound     r_lo, n_lo;
    t_bound     r_hi, n_hi;
    t_root      r_cand, n_cand;
    t_root      r_best, n_best;
    t_scaled    r_xs_lo, n_xs_lo;
    t_scaled    r_xs_hi, n_xs_hi;
    t_root      r_root;
    logic       r_out_valid;

    t_square              square;
    t_frac                fb;
    logic signed [DATA_WIDTH-1:0] x_in;
    t_root                x_mag;
    t_bound               one_fx;
    t_bound               hi_init;
    logic [BOUND_W:0]     sum_up;
    logic [BOUND_W:0]     sum_dn;
    logic                 sq_below;
    logic                 sq_hit;
    logic                 out_free;

    // Shared squarer.
    fpsqrt_sqr u_sqr (
        .i_clk    (i_clk),
        .i_cand   (r_cand),
        .o_square (square)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= t_frac'(FRAC_RESET);
        end else if (i_cfg_we) begin
            r_frac <= i_cfg_wdata;
        end
    end

    // Effective fraction bits and the load-time bounds.
    always_comb begin
        fb      = (r_frac > t_frac'(FRAC_MAX)) ? t_frac'(FRAC_MAX) : r_frac;
        x_in    = s_axis_tdata[DATA_WIDTH-1:0];
        x_mag   = x_in[ROOT_W-1:0];
        one_fx  = t_bound'(1) << fb;
        hi_init = (BOUND_W'(x_mag) > one_fx) ? BOUND_W'(x_mag) : one_fx;
    end

    // Compare the square against [x << fb, (x + 1) << fb) and form both
    // possible next candidates in parallel.
    always_comb begin
        sq_below = SCALED_W'(square) < r_xs_lo;
        sq_hit   = !sq_below && (SCALED_W'(square) < r_xs_hi);
        sum_up   = (BOUND_W+1)'(r_cand) + (BOUND_W+1)'(1) + (BOUND_W+1)'(r_hi);
        sum_dn   = (BOUND_W+1)'(r_lo) + (BOUND_W+1)'(r_cand) - (BOUND_W+1)'(1);
        out_free = !r_out_valid || m_axis_tready;
    end

    // Search sequencer.
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_cand  = r_cand;
        n_best  = r_best;
        n_xs_lo = r_xs_lo;
        n_xs_hi = r_xs_hi;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_best  = '0;
                    n_lo    = '0;
                    n_hi    = hi_init;
                    n_cand  = hi_init[BOUND_W-1:1];
                    n_xs_lo = SCALED_W'(x_mag) << fb;
                    n_xs_hi = (SCALED_W'(x_mag) + SCALED_W'(1)) << fb;
                    if (x_in <= 0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (sq_hit) begin
                    n_best  = r_cand;
                    n_state = ST_DONE;
                end else if (sq_below) begin
                    n_best = r_cand;
                    n_lo   = BOUND_W'(r_cand) + BOUND_W'(1);
                    n_cand = sum_up[ROOT_W:1];
                    n_state = (BOUND_W'(r_cand) >= r_hi) ? ST_DONE : ST_SQ;
                end else begin
                    n_hi   = BOUND_W'(r_cand) - BOUND_W'(1);
                    n_cand = sum_dn[ROOT_W:1];
                    n_state = (BOUND_W'(r_cand) <= r_lo) ? ST_DONE : ST_SQ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_cand  <= n_cand;
        r_best  <= n_best;
        r_xs_lo <= n_xs_lo;
        r_xs_hi <= n_xs_hi;
    end

    // Output register: loaded when a search ends and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_root <= r_best;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_OUT_W'(r_root);

endmodule : fixed_point_sqrt_bsearch_top

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point binary-search square root block.
// ----------------------------------------------------------------------------
// A directed table covers zero and negative inputs, the largest and smallest
// positive values, exact roots and the ends of the fraction-bit range,
// including the value that saturates. A random part then walks several
// fraction-bit settings with values spread over the whole input range,
// around perfect squares and just above zero. Every result is checked against
// a bit-accurate root search kept in the bench or, for zero and negative
// directed rows, a root typed in by hand. Both stream sides idle at random,
// and the receiver once holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import fpsqrt_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int CHUNKS         = 13;
    localparam int ITEMS_PER_CHNK = 150;
    localparam int DIR_ROWS       = 22;
    localparam int STALL_AFTER    = 300;    // results seen before the long hold-off
    localparam int STALL_CYCLES   = 400;
    localparam int SETTLE_CYCLES  = 80;     // longest search plus output slack
    localparam int WATCHDOG_LIMIT = 2000;

    // One pending expectation: the accepted value and its predicted root.
    typedef struct {
        logic [DATA_WIDTH-1:0] value;
        t_root                 root;
    } t_root_expect;

    // One row of the directed table; known marks a root typed in by hand.
    typedef struct packed {
        t_frac                 frac;
        logic [DATA_WIDTH-1:0] value;
        logic                  known;
        t_root                 root;
    } t_dir_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    t_frac                  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;   // [31:0] value
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;         // [30:0] root, [31] zero

    t_root_expect root_expect_q[$];
    t_dir_row     dir_rows [DIR_ROWS];
    t_frac        frac_shadow   = t_frac'(FRAC_RESET);
    int           src_idle_pct  = 9;
    int           sink_idle_pct = 48;
    int           err_count     = 0;
    int           results_seen  = 0;
    int           hold_left     = 0;
    bit           stall_done    = 1'b0;
    int           idle_cycles   = 0;

    fixed_point_sqrt_bsearch_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Binary search over [0, max(x, 1.0)] with squares formed at 64 bits.
    function automatic t_root predict_root(input logic [DATA_WIDTH-1:0] raw,
                                           input t_frac frac);
        longint          x;
        longint          lo;
        longint          hi;
        longint          one;
        longint          cand;
        longint unsigned ux;
        longint unsigned c;
        longint unsigned sq;
        int unsigned     fb;
        bit              found;
        t_root           best;
        fb    = (frac > FRAC_MAX) ? FRAC_MAX : frac;
        x     = longint'($signed(raw));
        best  = '0;
        found = 1'b0;
        if (x <= 0)
            return '0;
        ux  = x;
        one = longint'(1) << fb;
        lo  = 0;
        hi  = (x > one) ? x : one;
        while (!found && lo <= hi) begin
            cand = (lo + hi) / 2;
            c    = cand;
            sq   = (c * c) >> fb;
            if (sq == ux) begin
                best  = t_root'(c);
                found = 1'b1;
            end else if (sq < ux) begin
                best = t_root'(c);
                lo   = cand + 1;
            end else begin
                hi = cand - 1;
            end
        end
        return best;
    endfunction

    // Random input value: full range most often, also negative, corner values, near squares and small ones.
    function automatic logic [DATA_WIDTH-1:0] pick_value(input t_frac frac);
        int unsigned     eff;
        int unsigned     kind;
        int unsigned     rbits;
        longint unsigned r;
        longint unsigned sq;
        longint unsigned lim;
        eff  = (frac > FRAC_MAX) ? FRAC_MAX : frac;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                return $urandom();
            end
            4: begin
                return $urandom() | 32'h8000_0000;
            end
            5: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'h7FFF_FFFF;
                    default: return 32'd1 << eff;
                endcase
            end
            6, 7: begin
                rbits = (31 + eff) / 2;
                r     = $urandom_range(0, (32'd1 << rbits) - 1);
                sq    = ((r * r) >> eff) + $urandom_range(0, 2) - 1;
                return sq[DATA_WIDTH-1:0];
            end
            default: begin
                lim = 64'd4 << eff;
                if (lim > 64'h7FFF_FFFF)
                    lim = 64'h7FFF_FFFF;
                return $urandom_range(1, lim[31:0]);
            end
        endcase
    endfunction

    // Offer one item and wait for it to be taken; a known root overrides.
    task automatic send_value(input logic [DATA_WIDTH-1:0] value, input bit known,
                              input t_root root);
        t_root_expect entry;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        entry.value = value;
        entry.root  = known ? root : predict_root(value, frac_shadow);
        root_expect_q.push_back(entry);
    endtask

    // Stop offering and wait until every expected root has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (root_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the fraction bits; only called while the block is idle.
    task automatic write_frac(input t_frac frac);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= frac;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frac_shadow = frac;
    endtask

    // Compare one returned item with the oldest expectation.
    task automatic check_result(input logic [TDATA_OUT_W-1:0] data);
        t_root_expect entry;
        results_seen++;
        if (root_expect_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got %h", $time, data);
            err_count++;
        end else begin
            entry = root_expect_q.pop_front();
            if (data[ROOT_W-1:0] !== entry.root) begin
                $display("%0t: root of %h: expected %h, got %h", $time, entry.value,
                         entry.root, data[ROOT_W-1:0]);
                err_count++;
            end
            if (data[TDATA_OUT_W-1:ROOT_W] !== '0) begin
                $display("%0t: padding of %h: expected 0, got %h", $time, entry.value,
                         data[TDATA_OUT_W-1:ROOT_W]);
                err_count++;
            end
        end
    endtask

    // Receiver: checks results, idles at random and holds off once for long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (hold_left > 0) begin
                hold_left     = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!stall_done && results_seen >= STALL_AFTER) begin
                stall_done    = 1'b1;
                hold_left     = STALL_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random chunks per setting.
    initial begin
        t_frac frac;
        dir_rows = '{
            // Reset setting of sixteen fraction bits.
            {5'd16, 32'h0000_0000, 1'b1, 31'd0},
            {5'd16, 32'hFFFF_FFFF, 1'b1, 31'd0},
            {5'd16, 32'h8000_0000, 1'b1, 31'd0},
            {5'd16, 32'h0000_0001, 1'b0, 31'd0},
            {5'd16, 32'h0001_0000, 1'b0, 31'd0},
            {5'd16, 32'h0004_0000, 1'b0, 31'd0},
            {5'd16, 32'h7FFF_FFFF, 1'b0, 31'd0},
            // Plain integers.
            {5'd0,  32'h0000_0001, 1'b0, 31'd0},
            {5'd0,  32'h0000_0002, 1'b0, 31'd0},
            {5'd0,  32'h0000_0004, 1'b0, 31'd0},
            {5'd0,  32'h7FFF_FFFF, 1'b0, 31'd0},
            {5'd0,  32'h8000_0000, 1'b1, 31'd0},
            // Widest legal fraction; every input lies below two.
            {5'd30, 32'h0000_0001, 1'b0, 31'd0},
            {5'd30, 32'h4000_0000, 1'b0, 31'd0},
            {5'd30, 32'h7FFF_FFFF, 1'b0, 31'd0},
            {5'd30, 32'hC000_0000, 1'b1, 31'd0},
            // Out-of-range setting that must act as thirty.
            {5'd31, 32'h4000_0000, 1'b0, 31'd0},
            {5'd31, 32'h7FFF_FFFF, 1'b0, 31'd0},
            {5'd31, 32'h0000_0005, 1'b0, 31'd0},
            // One fraction bit.
            {5'd1,  32'h0000_0003, 1'b0, 31'd0},
            {5'd1,  32'h7FFF_FFFE, 1'b0, 31'd0},
            {5'd1,  32'h0000_0000, 1'b1, 31'd0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].frac != frac_shadow) begin
                drain_results();
                write_frac(dir_rows[i].frac);
            end
            send_value(dir_rows[i].value, dir_rows[i].known, dir_rows[i].root);
        end

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk)
                0:       frac = 5'd0;
                1:       frac = 5'd30;
                2:       frac = 5'd31;
                3:       frac = 5'd16;
                default: frac = t_frac'($urandom_range(0, 31));
            endcase
            drain_results();
            write_frac(frac);
            // Idling: receiver-heavy first, then sender-heavy, then none.
            if (chunk < 4) begin
                src_idle_pct  = 9;
                sink_idle_pct = 48;
            end else if (chunk < 9) begin
                src_idle_pct  = 48;
                sink_idle_pct = 9;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_CHNK; n++)
                send_value(pick_value(frac), 1'b0, '0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && root_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fpsqrt_pkg.sv
rtl/fpsqrt_sqr.sv
rtl/fixed_point_sqrt_bsearch_top.sv
tb/tb_top.sv
